### sv/rmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // default fixed-point fraction width of every input and output value
  localparam int FRAC_BITS_DEF = 14;

  // input element and output field widths
  localparam int ELEM_W = 16;
  localparam int QW_W   = 15;
  localparam int QV_W   = 16;

  // saturation limit of a quaternion part magnitude
  localparam int MAG_LIMIT = 32767;

  // quaternion lanes
  localparam int NUM_LANES = 4;
  localparam int LANE_W    = 0;
  localparam int LANE_X    = 1;
  localparam int LANE_Y    = 2;
  localparam int LANE_Z    = 3;

endpackage : rmq_pkg
`default_nettype wire

### sv/rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts the rotation part of a pose matrix (nine signed Q2.14 elements)
// into a quaternion (w, x, y, z) in the copysign form.
//
// Usage:
//   Input beat: in_valid with in_r00 .. in_r22; taken when in_stall is low.
//   Output beat: out_valid with out_quat_w/x/y/z; taken when out_stall is low.
//   One result beat per input beat, in order. No configuration, no state
//   beyond the pipeline itself.
//   Stage 0 forms the four diagonal sums, stages 1 .. ROOT_W each give one
//   root bit in the bit-serial square root pipeline (four roots side by
//   side), and the output stage does halving, saturation and sign.
//   Throughput is one matrix per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds its beat and the
//   pipeline keeps filling its empty stages; in_stall rises only once every
//   stage holds a beat.
//   Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
  import rmq_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic signed [ELEM_W-1:0] in_r00,
  input  wire logic signed [ELEM_W-1:0] in_r01,
  input  wire logic signed [ELEM_W-1:0] in_r02,
  input  wire logic signed [ELEM_W-1:0] in_r10,
  input  wire logic signed [ELEM_W-1:0] in_r11,
  input  wire logic signed [ELEM_W-1:0] in_r12,
  input  wire logic signed [ELEM_W-1:0] in_r20,
  input  wire logic signed [ELEM_W-1:0] in_r21,
  input  wire logic signed [ELEM_W-1:0] in_r22,

  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic        [QW_W-1:0]   out_quat_w,
  output      logic signed [QV_W-1:0]   out_quat_x,
  output      logic signed [QV_W-1:0]   out_quat_y,
  output      logic signed [QV_W-1:0]   out_quat_z
);

  // sum of one and three elements: room for one plus 3 * 2^15, with sign
  localparam int SUM_W  = ((FRACTION_BITS > ELEM_W + 1) ? FRACTION_BITS : ELEM_W + 1) + 3;
  localparam int ROOT_W = (SUM_W - 1 + FRACTION_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int EXT_W  = (ROOT_W - 1 > QV_W) ? ROOT_W - 1 : QV_W;
  localparam int LAST   = ROOT_W + 1;   // output stage index

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRACTION_BITS;

  typedef logic [RAD_W-1:0]  rad_t;
  typedef logic [REM_W-1:0]  rem_t;
  typedef logic [ROOT_W-1:0] root_t;

  // per-stage ready: a stage loads when it is empty or its successor moves
  logic [LAST+1:0] rdy;
  logic [LAST:0]   vld_r;

  // root pipeline registers, stages 0 .. ROOT_W
  rad_t  rad_r  [0:ROOT_W][NUM_LANES];
  rem_t  rem_r  [0:ROOT_W][NUM_LANES];
  root_t root_r [0:ROOT_W][NUM_LANES];
  logic  [NUM_LANES-1:0] neg_r [0:ROOT_W];

  always_comb begin
    rdy[LAST+1] = !out_stall;
    for (int k = LAST; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[LAST];

  // --------------------------------------------------------------------------
  // Stage 0: diagonal sums, clamp, radicand, sign of off-diagonal differences
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]    e00, e11, e22;
  logic signed [SUM_W-1:0]    sum [NUM_LANES];
  logic signed [ELEM_W:0]     dif [NUM_LANES];
  rad_t                       rad_nxt [NUM_LANES];
  logic [NUM_LANES-1:0]       neg_nxt;

  always_comb begin
    e00 = SUM_W'(in_r00);
    e11 = SUM_W'(in_r11);
    e22 = SUM_W'(in_r22);
    sum[LANE_W] = ONE + e00 + e11 + e22;
    sum[LANE_X] = ONE + e00 - e11 - e22;
    sum[LANE_Y] = ONE - e00 + e11 - e22;
    sum[LANE_Z] = ONE - e00 - e11 + e22;
    dif[LANE_W] = '0;
    dif[LANE_X] = (ELEM_W+1)'(in_r21) - (ELEM_W+1)'(in_r12);
    dif[LANE_Y] = (ELEM_W+1)'(in_r02) - (ELEM_W+1)'(in_r20);
    dif[LANE_Z] = (ELEM_W+1)'(in_r10) - (ELEM_W+1)'(in_r01);
    for (int l = 0; l < NUM_LANES; l++) begin
      // clamp a negative sum to zero
      if (sum[l][SUM_W-1]) begin
        rad_nxt[l] = '0;
      end else begin
        rad_nxt[l] = RAD_W'(sum[l][SUM_W-2:0]) << FRACTION_BITS;
      end
      neg_nxt[l] = dif[l][ELEM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rad_r[0][l]  <= rad_nxt[l];
        rem_r[0][l]  <= '0;
        root_r[0][l] <= '0;
      end
      neg_r[0] <= neg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1 .. ROOT_W: one root bit per stage, MSB first
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
    rem_t  cur   [NUM_LANES];
    rem_t  trial [NUM_LANES];
    rem_t  rem_nxt  [NUM_LANES];
    root_t root_nxt [NUM_LANES];

    always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
        // bring down the next two radicand bits
        cur[l]   = {rem_r[k-1][l][REM_W-3:0], rad_r[k-1][l][RAD_W-1 -: 2]};
        trial[l] = {root_r[k-1][l], 2'b01};
        if (cur[l] >= trial[l]) begin
          rem_nxt[l]  = cur[l] - trial[l];
          root_nxt[l] = {root_r[k-1][l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = cur[l];
          root_nxt[l] = {root_r[k-1][l][ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          rad_r[k][l]  <= rad_r[k-1][l] << 2;
          rem_r[k][l]  <= rem_nxt[l];
          root_r[k][l] <= root_nxt[l];
        end
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: halve, saturate, apply sign
  // --------------------------------------------------------------------------
  logic [EXT_W-1:0]      mag_ext [NUM_LANES];
  logic [QW_W-1:0]       mag     [NUM_LANES];
  logic signed [QV_W-1:0] sgn    [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mag_ext[l] = EXT_W'(root_r[ROOT_W][l] >> 1);
      if (mag_ext[l] > EXT_W'(MAG_LIMIT)) begin
        mag[l] = QW_W'(MAG_LIMIT);
      end else begin
        mag[l] = mag_ext[l][QW_W-1:0];
      end
      if (neg_r[ROOT_W][l]) begin
        sgn[l] = -$signed({1'b0, mag[l]});
      end else begin
        sgn[l] = $signed({1'b0, mag[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[LAST] <= 1'b0;
    end else if (rdy[LAST]) begin
      vld_r[LAST] <= vld_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      out_quat_w <= mag[LANE_W];
      out_quat_x <= sgn[LANE_X];
      out_quat_y <= sgn[LANE_Y];
      out_quat_z <= sgn[LANE_Z];
    end
  end

endmodule : rotation_matrix_to_quaternion_unit
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rotation_matrix_to_quaternion_unit. Drives pose
// matrices through the valid/stall input channel and predicts each
// quaternion in a scoreboard. Every quaternion beat is compared in order,
// lane by lane. Runs directed corner matrices, then random matrices under
// three idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import rmq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 25;
  localparam int RANDOM_PER_MIX = 150;
  localparam int ONE_Q          = 1 << FRAC_BITS_DEF;

  typedef struct {
    logic signed [ELEM_W-1:0] r [3][3];
  } matrix_t;

  typedef struct {
    logic        [QW_W-1:0] w;
    logic signed [QV_W-1:0] x;
    logic signed [QV_W-1:0] y;
    logic signed [QV_W-1:0] z;
  } quat_t;

  class quat_scoreboard;
    quat_t expected_q[$];
    int    mismatches;
    int    checked;
    int    clamped_lanes;
    int    negative_parts;

    // floor(sqrt(total << FRAC_BITS)) / 2, saturated at MAG_LIMIT, zero for a negative total
    function logic [QV_W-1:0] half_root(int total);
      longint unsigned radicand;
      longint unsigned root;
      longint unsigned trial;
      if (total <= 0) return '0;
      radicand = longint'(total) << FRAC_BITS_DEF;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= radicand) root = trial;
      end
      root = root >> 1;
      if (root > MAG_LIMIT) root = MAG_LIMIT;
      return root[QV_W-1:0];
    endfunction

    // a zero difference keeps the positive sign
    function logic signed [QV_W-1:0] signed_part(logic [QV_W-1:0] mag, int diff);
      if (diff < 0) begin
        if (mag != 0) negative_parts++;
        return -mag;
      end
      return mag;
    endfunction

    function void note_matrix(matrix_t m);
      int              a [3][3];
      int              sums [NUM_LANES];
      logic [QV_W-1:0] mag_w;
      quat_t           q;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          a[i][j] = m.r[i][j];
      sums[LANE_W] = ONE_Q + a[0][0] + a[1][1] + a[2][2];
      sums[LANE_X] = ONE_Q + a[0][0] - a[1][1] - a[2][2];
      sums[LANE_Y] = ONE_Q - a[0][0] + a[1][1] - a[2][2];
      sums[LANE_Z] = ONE_Q - a[0][0] - a[1][1] + a[2][2];
      for (int l = 0; l < NUM_LANES; l++)
        if (sums[l] < 0) clamped_lanes++;
      mag_w = half_root(sums[LANE_W]);
      q.w = mag_w[QW_W-1:0];
      q.x = signed_part(half_root(sums[LANE_X]), a[2][1] - a[1][2]);
      q.y = signed_part(half_root(sums[LANE_Y]), a[0][2] - a[2][0]);
      q.z = signed_part(half_root(sums[LANE_Z]), a[1][0] - a[0][1]);
      expected_q.insert(expected_q.size(), q);
    endfunction

    function void check_quat(logic [QW_W-1:0] w, logic signed [QV_W-1:0] x,
                             logic signed [QV_W-1:0] y, logic signed [QV_W-1:0] z);
      quat_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: quaternion beat with nothing outstanding: w=%0d x=%0d y=%0d z=%0d",
                   $time, w, x, y, z);
        return;
      end
      e = expected_q.pop_front();
      if (e.w !== w || e.x !== x || e.y !== y || e.z !== z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: quaternion mismatch: expected w=%0d x=%0d y=%0d z=%0d,",
                   $time, e.w, e.x, e.y, e.z,
                   " got w=%0d x=%0d y=%0d z=%0d", w, x, y, z);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic signed [ELEM_W-1:0] in_r00 = '0, in_r01 = '0, in_r02 = '0;
  logic signed [ELEM_W-1:0] in_r10 = '0, in_r11 = '0, in_r12 = '0;
  logic signed [ELEM_W-1:0] in_r20 = '0, in_r21 = '0, in_r22 = '0;
  logic                   out_valid;
  logic        [QW_W-1:0] out_quat_w;
  logic signed [QV_W-1:0] out_quat_x, out_quat_y, out_quat_z;

  quat_scoreboard quat_sb = new;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int idle_cycles  = 0;
  int sent         = 0;

  rotation_matrix_to_quaternion_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_r00     (in_r00),
    .in_r01     (in_r01),
    .in_r02     (in_r02),
    .in_r10     (in_r10),
    .in_r11     (in_r11),
    .in_r12     (in_r12),
    .in_r20     (in_r20),
    .in_r21     (in_r21),
    .in_r22     (in_r22),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_quat_w (out_quat_w),
    .out_quat_x (out_quat_x),
    .out_quat_y (out_quat_y),
    .out_quat_z (out_quat_z)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      quat_sb.check_quat(out_quat_w, out_quat_x, out_quat_y, out_quat_z);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("rotation_matrix_to_quaternion_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic matrix_t make_matrix(int e00, int e01, int e02,
                                          int e10, int e11, int e12,
                                          int e20, int e21, int e22);
    matrix_t m;
    m.r[0][0] = ELEM_W'(e00); m.r[0][1] = ELEM_W'(e01); m.r[0][2] = ELEM_W'(e02);
    m.r[1][0] = ELEM_W'(e10); m.r[1][1] = ELEM_W'(e11); m.r[1][2] = ELEM_W'(e12);
    m.r[2][0] = ELEM_W'(e20); m.r[2][1] = ELEM_W'(e21); m.r[2][2] = ELEM_W'(e22);
    return m;
  endfunction

  // mix of raw noise, values within +/-20000 and boundary values
  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        if (kind < 45) begin
          m.r[i][j] = ELEM_W'($urandom);
        end else if (kind < 80) begin
          m.r[i][j] = ELEM_W'(int'($urandom_range(40000)) - 20000);
        end else begin
          case ($urandom_range(5))
            0:       m.r[i][j] = ELEM_W'(-32768);
            1:       m.r[i][j] = ELEM_W'(-1);
            2:       m.r[i][j] = ELEM_W'(0);
            3:       m.r[i][j] = ELEM_W'(1);
            4:       m.r[i][j] = ELEM_W'(ONE_Q);
            default: m.r[i][j] = ELEM_W'(32767);
          endcase
        end
      end
    // force zero off-diagonal differences now and then
    if ($urandom_range(4) == 0) m.r[1][2] = m.r[2][1];
    if ($urandom_range(4) == 0) m.r[2][0] = m.r[0][2];
    if ($urandom_range(4) == 0) m.r[0][1] = m.r[1][0];
    return m;
  endfunction

  // hold the beat until taken, then idle at random
  task automatic send_matrix(input matrix_t m);
    in_valid <= 1'b1;
    in_r00 <= m.r[0][0]; in_r01 <= m.r[0][1]; in_r02 <= m.r[0][2];
    in_r10 <= m.r[1][0]; in_r11 <= m.r[1][1]; in_r12 <= m.r[1][2];
    in_r20 <= m.r[2][0]; in_r21 <= m.r[2][1]; in_r22 <= m.r[2][2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_sb.note_matrix(m);
    sent++;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (quat_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_matrix(make_matrix(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768));
    // half turns: three lanes land exactly on a zero sum
    send_matrix(make_matrix(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
    send_matrix(make_matrix(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q));
    send_matrix(make_matrix(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q));
    // quarter turns both ways about each axis
    send_matrix(make_matrix(0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q));
    send_matrix(make_matrix(0, ONE_Q, 0, -ONE_Q, 0, 0, 0, 0, ONE_Q));
    send_matrix(make_matrix(ONE_Q, 0, 0, 0, 0, -ONE_Q, 0, ONE_Q, 0));
    send_matrix(make_matrix(ONE_Q, 0, 0, 0, 0, ONE_Q, 0, -ONE_Q, 0));
    send_matrix(make_matrix(0, 0, ONE_Q, 0, ONE_Q, 0, -ONE_Q, 0, 0));
    send_matrix(make_matrix(0, 0, -ONE_Q, 0, ONE_Q, 0, ONE_Q, 0, 0));
    send_matrix(make_matrix(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
    send_matrix(make_matrix(0, -32768, -32768, -32768, 0, -32768, 32767, 32767, 0));
    send_matrix(make_matrix(21845, -21846, 21845, -21846, 21845, -21846,
                            21845, -21846, 21845));
    // zero-magnitude x with a negative and with a positive difference
    send_matrix(make_matrix(-ONE_Q, 0, 0, 0, 0, 1, 0, 0, 0));
    send_matrix(make_matrix(-ONE_Q - 1, 0, 0, 0, 0, 0, 0, 1, 0));
    // largest sums on the vector lanes
    send_matrix(make_matrix(32767, 5, -5, 5, -32768, 5, -5, -5, -32768));
    send_matrix(make_matrix(-32768, -7, 7, 7, 32767, -7, 7, 7, -32768));
    send_matrix(make_matrix(-32768, 3, 3, -3, -32768, 3, -3, -3, 32767));
    send_matrix(make_matrix(11585, -11585, 0, 11585, 11585, 0, 0, 0, ONE_Q));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct  = 22;
    rx_stall_pct = 82;
    run_directed();
    // hold the sender off until the pipeline is empty
    drain_results();
    for (int mix = 0; mix < 3; mix++) begin
      tx_idle_pct  = (mix == 0) ? 22 : (mix == 1) ? 82 : 0;
      rx_stall_pct = (mix == 0) ? 82 : (mix == 1) ? 22 : 0;
      repeat (RANDOM_PER_MIX) send_matrix(random_matrix());
      drain_results();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d matrices over three idle/stall mixes, %0d quaternion beats checked.",
             sent, quat_sb.checked);
    $display("Lanes clamped at zero: %0d, negative vector parts: %0d, mismatches: %0d.",
             quat_sb.clamped_lanes, quat_sb.negative_parts, quat_sb.mismatches);
    if (quat_sb.mismatches == 0 && quat_sb.pending() == 0) begin
      $display("rotation_matrix_to_quaternion_unit test passed");
    end else begin
      $display("rotation_matrix_to_quaternion_unit test failed");
    end
    $finish;
  end

endmodule
